// ----- hdl/hnfc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hnfc_pkg
// Shared types and constants of the Hermite normal form check core.
// ----------------------------------------------------------------------------
package hnfc_pkg;

  // Width of the dimension registers and of row/column counters.
  localparam int DIM_W = 5;
  // Counters that span one matrix (at most 31 x 31 entries).
  localparam int CNT_W = 2 * DIM_W;
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam int ENTRY_IN_W = 32;

  localparam int DEF_MAX_ROWS = 16;
  localparam int DEF_MAX_COLS = 16;
  localparam int DEF_ENTRY_WIDTH = 32;

  localparam logic [DIM_W-1:0] ROW_COUNT_RST = 5'd16;
  localparam logic [DIM_W-1:0] COL_COUNT_RST = 5'd16;

  // Register index, taken from paddr[2].
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_ROW_RD,
    S_ROW_EV,
    S_ABV_RD,
    S_ABV_EV,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic start;
    logic rd_row;
    logic rd_abv;
    logic col_next;
    logic take_pivot;
    logic above_next;
    logic row_next;
    logic zero_row;
    logic mark_pass;
    logic mark_fail;
    logic set_result;
  } cmd_t;

  typedef struct packed {
    logic dims_empty;
    logic data_nz;
    logic data_neg;
    logic order_bad;
    logic zero_seen;
    logic above_bad;
    logic above_last;
    logic col_last;
    logic row_last;
    logic first_row;
  } status_t;

endpackage
`default_nettype wire

// ----- hdl/hnfc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hnfc_ctrl
// Sequencer: loads entries, walks the stored matrix, hands off the verdict.
// ----------------------------------------------------------------------------
module hnfc_ctrl
  import hnfc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire status_t status_i,
  input  wire logic    s_tvalid_i,
  input  wire logic    s_tlast_i,
  output logic         s_tready_o,
  input  wire logic    m_tready_i,
  output logic         m_tvalid_o,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (s_tvalid_i && s_tlast_i) state_d = S_START;
      end
      S_START: begin
        state_d = status_i.dims_empty ? S_DONE : S_ROW_RD;
      end
      S_ROW_RD: state_d = S_ROW_EV;
      S_ROW_EV: begin
        if (status_i.data_nz) begin
          if (status_i.zero_seen || status_i.data_neg || status_i.order_bad) begin
            state_d = S_DONE;
          end else if (!status_i.first_row) begin
            state_d = S_ABV_RD;
          end else begin
            state_d = status_i.row_last ? S_DONE : S_ROW_RD;
          end
        end else if (status_i.col_last) begin
          state_d = status_i.row_last ? S_DONE : S_ROW_RD;
        end else begin
          state_d = S_ROW_RD;
        end
      end
      S_ABV_RD: state_d = S_ABV_EV;
      S_ABV_EV: begin
        if (status_i.above_bad) begin
          state_d = S_DONE;
        end else if (status_i.above_last) begin
          state_d = status_i.row_last ? S_DONE : S_ROW_RD;
        end else begin
          state_d = S_ABV_RD;
        end
      end
      S_DONE: begin
        if (slot_free) state_d = S_LOAD;
      end
      default: state_d = S_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        s_tready_o = 1'b1;
        cmd_o.load = s_tvalid_i;
      end
      S_START: begin
        if (status_i.dims_empty) cmd_o.mark_pass = 1'b1;
        else                     cmd_o.start     = 1'b1;
      end
      S_ROW_RD: cmd_o.rd_row = 1'b1;
      S_ROW_EV: begin
        if (status_i.data_nz) begin
          if (status_i.zero_seen || status_i.data_neg || status_i.order_bad) begin
            cmd_o.mark_fail = 1'b1;
          end else begin
            cmd_o.take_pivot = 1'b1;
            if (status_i.first_row) begin
              if (status_i.row_last) cmd_o.mark_pass = 1'b1;
              else                   cmd_o.row_next  = 1'b1;
            end
          end
        end else if (status_i.col_last) begin
          cmd_o.zero_row = 1'b1;
          if (status_i.row_last) cmd_o.mark_pass = 1'b1;
          else                   cmd_o.row_next  = 1'b1;
        end else begin
          cmd_o.col_next = 1'b1;
        end
      end
      S_ABV_RD: cmd_o.rd_abv = 1'b1;
      S_ABV_EV: begin
        if (status_i.above_bad) begin
          cmd_o.mark_fail = 1'b1;
        end else if (status_i.above_last) begin
          if (status_i.row_last) cmd_o.mark_pass = 1'b1;
          else                   cmd_o.row_next  = 1'b1;
        end else begin
          cmd_o.above_next = 1'b1;
        end
      end
      S_DONE: cmd_o.set_result = slot_free;
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.set_result) out_valid_d = 1'b1;
    else if (m_tready_i)  out_valid_d = 1'b0;
  end

  assign m_tvalid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- hdl/hnfc_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hnfc_datapath
// Matrix store, scan counters and the pivot and range compares.
// ----------------------------------------------------------------------------
module hnfc_datapath
  import hnfc_pkg::*;
#(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output status_t                    status_o,
  input  wire logic [DIM_W-1:0]      row_count_i,
  input  wire logic [DIM_W-1:0]      col_count_i,
  input  wire logic [ENTRY_IN_W-1:0] entry_i,
  output logic                       result_o
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [ENTRY_WIDTH-1:0] mem [DEPTH];
  logic signed [ENTRY_WIDTH-1:0] rdata_q;
  logic signed [ENTRY_WIDTH-1:0] pivot_q;
  logic signed [ENTRY_WIDTH-1:0] entry_narrow;
  logic signed [63:0]            entry_ext;

  logic [DIM_W-1:0] rows_used, cols_used;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] load_cnt_q;
  logic [CNT_W-1:0] row_base_q, abv_addr_q, row_addr;
  logic [DIM_W-1:0] row_i_q, col_j_q, abv_i_q, prior_col_q;
  logic             has_prior_q, zero_seen_q, verdict_q, result_q;
  logic             wr_en;
  logic [AW-1:0]    wr_addr, rd_addr;

  // Clamp the dimensions to the store geometry.
  assign rows_used = (32'(row_count_i) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : row_count_i;
  assign cols_used = (32'(col_count_i) > MAX_COLS) ? DIM_W'(MAX_COLS) : col_count_i;
  assign total     = CNT_W'(rows_used) * CNT_W'(cols_used);

  // Sign-extend the input, keep ENTRY_WIDTH bits.
  assign entry_ext    = 64'(signed'(entry_i));
  assign entry_narrow = entry_ext[ENTRY_WIDTH-1:0];

  assign wr_en    = cmd_i.load && (load_cnt_q < total);
  assign wr_addr  = AW'(load_cnt_q);
  assign row_addr = row_base_q + CNT_W'(col_j_q);
  assign rd_addr  = AW'(cmd_i.rd_abv ? abv_addr_q : row_addr);

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= entry_narrow;
    if (cmd_i.rd_row || cmd_i.rd_abv) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      has_prior_q <= 1'b0;
      zero_seen_q <= 1'b0;
    end else begin
      if (cmd_i.set_result) load_cnt_q <= '0;
      else if (wr_en)       load_cnt_q <= load_cnt_q + 1'b1;
      if (cmd_i.start) begin
        has_prior_q <= 1'b0;
        zero_seen_q <= 1'b0;
      end else begin
        if (cmd_i.take_pivot) has_prior_q <= 1'b1;
        if (cmd_i.zero_row)   zero_seen_q <= 1'b1;
      end
    end
  end

  // Scan counters and payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      row_i_q    <= '0;
      col_j_q    <= '0;
      row_base_q <= '0;
    end else begin
      if (cmd_i.col_next) col_j_q <= col_j_q + 1'b1;
      if (cmd_i.row_next) begin
        row_i_q    <= row_i_q + 1'b1;
        col_j_q    <= '0;
        row_base_q <= row_base_q + CNT_W'(cols_used);
      end
    end
    if (cmd_i.take_pivot) begin
      pivot_q     <= rdata_q;
      prior_col_q <= col_j_q;
      abv_i_q     <= '0;
      abv_addr_q  <= CNT_W'(col_j_q);
    end else if (cmd_i.above_next) begin
      abv_i_q    <= abv_i_q + 1'b1;
      abv_addr_q <= abv_addr_q + CNT_W'(cols_used);
    end
    if (cmd_i.mark_pass)      verdict_q <= 1'b1;
    else if (cmd_i.mark_fail) verdict_q <= 1'b0;
    if (cmd_i.set_result) result_q <= verdict_q;
  end

  assign status_o.dims_empty = (rows_used == '0) || (cols_used == '0);
  assign status_o.data_nz    = (rdata_q != '0);
  assign status_o.data_neg   = rdata_q[ENTRY_WIDTH-1];
  assign status_o.order_bad  = has_prior_q && (col_j_q <= prior_col_q);
  assign status_o.zero_seen  = zero_seen_q;
  assign status_o.above_bad  = rdata_q[ENTRY_WIDTH-1] || (rdata_q >= pivot_q);
  assign status_o.above_last = (DIM_W'(abv_i_q + 1'b1) == row_i_q);
  assign status_o.col_last   = (DIM_W'(col_j_q + 1'b1) == cols_used);
  assign status_o.row_last   = (DIM_W'(row_i_q + 1'b1) == rows_used);
  assign status_o.first_row  = (row_i_q == '0);

  assign result_o = result_q;

endmodule
`default_nettype wire

// ----- hdl/hermite_normal_form_check_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hermite_normal_form_check_core
// Loads a matrix entry by entry and flags whether it is in Hermite normal form.
// ----------------------------------------------------------------------------
//
//  channel   direction  carries                       accepted when
//  s_axis    in         matrix_entry, last_entry      s_axis_tvalid & s_axis_tready
//  m_axis    out        is_hnf                        m_axis_tvalid & m_axis_tready
//  apb       in/out     row_count, col_count          psel & penable & pwrite
//
// Entries are accepted while the core is in its load state. After the last entry
// the check walks the store through its single registered read port: up to
// rows*cols reads for the pivot search plus up to rows*(rows-1)/2 reads of the
// columns above the pivots, plus a start step and a hand-off step.
// Reset leaves the store undefined, the entry count at zero and both
// dimensions at 16. A stalled result holds in the output register while the
// next matrix already loads; the next verdict waits until it is taken.
//
module hermite_normal_form_check_core
  import hnfc_pkg::*;
#(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // stream in
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [ENTRY_IN_W-1:0] s_axis_tdata,  // [31:0] matrix_entry
  input  wire logic                  s_axis_tlast,  // last_entry
  // stream out
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [7:0]                 m_axis_tdata,  // [0] is_hnf, [7:1] zero
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_AW-1:0]     paddr,
  input  wire logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]          prdata,
  output logic                       pready
);

  logic [DIM_W-1:0] row_count_q, col_count_q;
  logic             cfg_wr;
  cmd_t             cmd;
  status_t          status;
  logic             result;

  // Configuration registers: one request completes per access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= ROW_COUNT_RST;
      col_count_q <= COL_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_ROW_COUNT: row_count_q <= pwdata[DIM_W-1:0];
        REG_COL_COUNT: col_count_q <= pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_ROW_COUNT: prdata = APB_DW'(row_count_q);
      REG_COL_COUNT: prdata = APB_DW'(col_count_q);
      default:       prdata = '0;
    endcase
  end

  hnfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (status),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .cmd_o      (cmd)
  );

  hnfc_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .row_count_i (row_count_q),
    .col_count_i (col_count_q),
    .entry_i     (s_axis_tdata),
    .result_o    (result)
  );

  assign m_axis_tdata = {7'b0, result};

  // Loading and scanning never overlap.
  a_no_load_during_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && (cmd.rd_row || cmd.rd_abv)))
    else $error("store read while entries load");

  // A last entry closes the input until the verdict is handed off.
  a_last_closes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still open after last entry");

  // A new verdict never overwrites one that is still waiting.
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.set_result |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
